// File: src/tri_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tri_pkg: shared types and constants
// Payload structs, register indexes and state codes for the frame split block.
// ----------------------------------------------------------------------------
package tri_pkg;

   localparam int IDX_W   = 24;
   localparam int CRD_W   = 32;
   localparam int WGT_W   = 16;
   localparam int FRAC_W  = 16;
   localparam int CSR_W   = 24;
   localparam int CSR_A_W = 1;
   localparam int LEN_W   = 34;   // side length, sqrt of a sum below 2^67
   localparam int SQ_W    = 68;   // sum of squares
   localparam int PER_W   = 36;   // perimeter

   localparam logic [CSR_A_W-1:0] CSR_FRACTION = 1'b0;
   localparam logic [CSR_A_W-1:0] CSR_BASE     = 1'b1;

   localparam logic KIND_VERTEX = 1'b0;
   localparam logic KIND_FACE   = 1'b1;

   typedef struct packed {
      logic [IDX_W-1:0]        first_index;
      logic [IDX_W-1:0]        second_index;
      logic [IDX_W-1:0]        third_index;
      logic signed [CRD_W-1:0] ax;
      logic signed [CRD_W-1:0] ay;
      logic signed [CRD_W-1:0] az;
      logic signed [CRD_W-1:0] bx;
      logic signed [CRD_W-1:0] by_coord;
      logic signed [CRD_W-1:0] bz;
      logic signed [CRD_W-1:0] cx;
      logic signed [CRD_W-1:0] cy;
      logic signed [CRD_W-1:0] cz;
   } req_type;

   typedef struct packed {
      logic                    record_kind;
      logic signed [CRD_W-1:0] vertex_x;
      logic signed [CRD_W-1:0] vertex_y;
      logic signed [CRD_W-1:0] vertex_z;
      logic [IDX_W-1:0]        face_first;
      logic [IDX_W-1:0]        face_second;
      logic [IDX_W-1:0]        face_third;
      logic                    index_overflow;
      logic                    last;
   } rsp_type;

   // front part to back part: triangle plus its new base index
   typedef struct packed {
      req_type          shape;
      logic [IDX_W-1:0] base;
      logic             ovf;
   } job_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SQUARE, ST_ROOT, ST_PERIM, ST_DIVIDE,
      ST_CENTER, ST_CSUM, ST_INSET, ST_EMIT
   } back_state_type;

endpackage

// File: src/tri_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tri_front: request intake
// Accepts triangles, assigns new vertex indices and tracks the vertex count.
// ----------------------------------------------------------------------------
module tri_front import tri_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   input  logic [IDX_W-1:0] vertex_base,
   output logic             job_valid,
   input  logic             job_full,
   output job_type          job_data
);

   logic [IDX_W-1:0] count_ff, count_in;
   logic [IDX_W:0]   j_wide, cnt_plus3;
   logic [IDX_W+1:0] j_plus2;
   localparam logic [IDX_W:0] IDX_MAX = {1'b0, {IDX_W{1'b1}}};

   assign req_stall = job_full;
   assign job_valid = req_valid & ~job_full;

   // new base index and overflow check
   always_comb begin
      j_wide    = {1'b0, vertex_base} + {1'b0, count_ff};
      j_plus2   = {1'b0, j_wide} + (IDX_W+2)'(2);
      cnt_plus3 = {1'b0, count_ff} + (IDX_W+1)'(3);
      count_in  = (cnt_plus3 > IDX_MAX) ? {IDX_W{1'b1}} : cnt_plus3[IDX_W-1:0];
      job_data.shape = req_data;
      job_data.base  = j_wide[IDX_W-1:0];
      job_data.ovf   = j_plus2 > {1'b0, IDX_MAX};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (job_valid) begin
         count_ff <= count_in;
      end
   end

endmodule

// File: src/tri_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tri_queue: two-entry job queue
// Decouples intake from the geometry engine.
// ----------------------------------------------------------------------------
module tri_queue import tri_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   output logic    full,
   output logic    not_empty,
   input  logic    pop,
   output job_type pop_data
);

   job_type    mem_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] cnt_ff;

   assign full      = cnt_ff == 2'd2;
   assign not_empty = cnt_ff != 2'd0;
   assign pop_data  = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop)  rd_ff <= ~rd_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("push into full queue");
   assert property (@(posedge clock) disable iff (reset) !(pop && !not_empty))
      else $error("pop from empty queue");
   assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("queue count out of range");

endmodule

// File: src/tri_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tri_back: geometry engine and record emitter
// Side lengths by bit-serial square root, weights by restoring division,
// incenter and inset per axis on one shared multiplier, then nine records.
// ----------------------------------------------------------------------------
module tri_back import tri_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_ready,
   input  job_type           job_data,
   output logic              job_pop,
   input  logic [FRAC_W-1:0] inset_fraction,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data
);

   back_state_type state_ff, state_in;
   job_type        job_ff;
   logic [5:0]     step_ff, step_in;         // general step counter
   logic [1:0]     side_ff, side_in;         // side / axis / corner index
   logic [1:0]     sub_ff, sub_in;           // sub index
   logic [3:0]     rec_ff, rec_in;

   logic signed [CRD_W:0]   dif_ff [3];      // current side deltas
   logic [SQ_W-1:0]         sq_ff;           // sum of squares
   logic [LEN_W-1:0]        root_ff;
   logic [LEN_W-1:0]        len_ff [3];      // la, lb, lc
   logic [PER_W-1:0]        per_ff;
   logic [PER_W+WGT_W-1:0]  rem_ff;
   logic [WGT_W:0]          quo_ff;
   logic [WGT_W:0]          wgt_ff [2];      // wb, wc
   logic signed [CRD_W+WGT_W+2:0] prod_ff;
   logic signed [CRD_W+WGT_W+3:0] acc_ff;
   logic signed [CRD_W+1:0]  ctr_ff [3];     // incenter per axis
   logic signed [CRD_W-1:0]  ins_ff [3][3];  // inset corner, axis

   // corner coordinate lookup
   function automatic logic signed [CRD_W-1:0] crd(req_type t, logic [1:0] k,
                                                   logic [1:0] a);
      logic signed [CRD_W-1:0] v;
      case ({k, a})
         4'h0: v = t.ax;  4'h1: v = t.ay;       4'h2: v = t.az;
         4'h4: v = t.bx;  4'h5: v = t.by_coord; 4'h6: v = t.bz;
         4'h8: v = t.cx;  4'h9: v = t.cy;       4'hA: v = t.cz;
         default: v = '0;
      endcase
      return v;
   endfunction

   // shared multiplier operands (one 34x34 product per cycle)
   logic signed [CRD_W+1:0] mul_a;
   logic signed [CRD_W+1:0] mul_b;
   logic signed [2*CRD_W+3:0] mul_p;
   logic [LEN_W-1:0] trial;
   logic [SQ_W+1:0]  trial_sq;
   always_comb begin
      trial    = root_ff | (LEN_W'(1) << step_ff);
      trial_sq = (SQ_W+2)'(trial) * (SQ_W+2)'(trial);
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_SQUARE: begin
            mul_a = (CRD_W+2)'(dif_ff[sub_ff]);
            mul_b = (CRD_W+2)'(dif_ff[sub_ff]);
         end
         ST_CENTER: begin
            mul_a = (CRD_W+2)'($signed({1'b0, wgt_ff[sub_ff[0]]}));
            mul_b = (CRD_W+2)'(crd(job_ff.shape, sub_ff[0] ? 2'd2 : 2'd1, side_ff))
                  - (CRD_W+2)'(crd(job_ff.shape, 2'd0, side_ff));
         end
         ST_INSET: begin
            mul_a = (CRD_W+2)'($signed({1'b0, inset_fraction}));
            mul_b = ctr_ff[side_ff] - (CRD_W+2)'(crd(job_ff.shape, sub_ff, side_ff));
         end
         default: ;
      endcase
      mul_p = mul_a * mul_b;
   end

   logic signed [CRD_W+2:0]       ins_sum;
   logic [PER_W+WGT_W-1:0]        rem_sh;
   logic [PER_W+WGT_W-1:0]        per_al;
   always_comb begin
      ins_sum = (CRD_W+3)'(crd(job_ff.shape, sub_ff, side_ff))
              + (CRD_W+3)'(prod_ff >>> FRAC_W);
      rem_sh  = rem_ff;
      per_al  = (PER_W+WGT_W)'(per_ff) << step_ff[4:0];
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      side_in  = side_ff;
      sub_in   = sub_ff;
      rec_in   = rec_ff;
      job_pop  = 1'b0;
      case (state_ff)
         ST_IDLE: if (job_ready) begin
            job_pop  = 1'b1;
            state_in = ST_SQUARE;
            side_in  = 2'd0;
            sub_in   = 2'd0;
         end
         ST_SQUARE: begin
            sub_in = sub_ff + 2'd1;
            if (sub_ff == 2'd2) begin
               sub_in   = 2'd0;
               step_in  = 6'(LEN_W-1);
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            step_in = step_ff - 6'd1;
            if (step_ff == 6'd0) begin
               if (side_ff == 2'd2) begin
                  state_in = ST_PERIM;
               end else begin
                  side_in  = side_ff + 2'd1;
                  state_in = ST_SQUARE;
               end
            end
         end
         ST_PERIM: begin
            state_in = ST_DIVIDE;
            step_in  = 6'(WGT_W);
            sub_in   = 2'd0;
         end
         ST_DIVIDE: begin
            step_in = step_ff - 6'd1;
            if (step_ff == 6'd0) begin
               step_in = 6'(WGT_W);
               if (sub_ff == 2'd1) begin
                  state_in = ST_CENTER;
                  side_in  = 2'd0;
                  sub_in   = 2'd0;
                  step_in  = 6'd0;
               end else begin
                  sub_in = 2'd1;
               end
            end
         end
         ST_CENTER: begin
            // step 0,1 multiply; ST_CSUM adds last product
            sub_in  = sub_ff ^ 2'd1;
            step_in = step_ff + 6'd1;
            if (step_ff == 6'd1) begin
               state_in = ST_CSUM;
            end
         end
         ST_CSUM: begin
            step_in = 6'd0;
            sub_in  = 2'd0;
            if (side_ff == 2'd2) begin
               side_in  = 2'd0;
               state_in = ST_INSET;
            end else begin
               side_in  = side_ff + 2'd1;
               state_in = ST_CENTER;
            end
         end
         ST_INSET: begin
            // step 0 multiply, step 1 write back
            step_in = step_ff + 6'd1;
            if (step_ff == 6'd1) begin
               step_in = 6'd0;
               if (side_ff == 2'd2) begin
                  side_in = 2'd0;
                  if (sub_ff == 2'd2) begin
                     state_in = ST_EMIT;
                     rec_in   = 4'd0;
                  end else begin
                     sub_in = sub_ff + 2'd1;
                  end
               end else begin
                  side_in = side_ff + 2'd1;
               end
            end
         end
         ST_EMIT: if (!rsp_stall) begin
            rec_in = rec_ff + 4'd1;
            if (rec_ff == 4'd8) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         side_ff  <= '0;
         sub_ff   <= '0;
         rec_ff   <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         side_ff  <= side_in;
         sub_ff   <= sub_in;
         rec_ff   <= rec_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            job_ff <= job_data;
            sq_ff  <= '0;
            for (int a = 0; a < 3; a++) begin
               dif_ff[a] <= (CRD_W+1)'(crd(job_data.shape, 2'd1, 2'(a)))
                          - (CRD_W+1)'(crd(job_data.shape, 2'd2, 2'(a)));
            end
         end
         ST_SQUARE: begin
            sq_ff   <= sq_ff + SQ_W'(mul_p);
            root_ff <= '0;
         end
         ST_ROOT: begin
            if (trial_sq <= (SQ_W+2)'(sq_ff)) root_ff <= trial;
            if (step_ff == 6'd0) begin
               len_ff[side_ff] <= (trial_sq <= (SQ_W+2)'(sq_ff)) ? trial : root_ff;
               sq_ff <= '0;
               // next side deltas
               for (int a = 0; a < 3; a++) begin
                  if (side_ff == 2'd0)
                     dif_ff[a] <= (CRD_W+1)'(crd(job_ff.shape, 2'd2, 2'(a)))
                                - (CRD_W+1)'(crd(job_ff.shape, 2'd0, 2'(a)));
                  else
                     dif_ff[a] <= (CRD_W+1)'(crd(job_ff.shape, 2'd0, 2'(a)))
                                - (CRD_W+1)'(crd(job_ff.shape, 2'd1, 2'(a)));
               end
            end
         end
         ST_PERIM: begin
            per_ff <= PER_W'(len_ff[0]) + PER_W'(len_ff[1]) + PER_W'(len_ff[2]);
            rem_ff <= (PER_W+WGT_W)'(len_ff[1]) << WGT_W;
            quo_ff <= '0;
         end
         ST_DIVIDE: begin
            // restoring division, one quotient bit per cycle
            if (step_ff == 6'd0) begin
               wgt_ff[sub_ff[0]] <= (per_ff != '0 && rem_sh >= per_al)
                                  ? (quo_ff | (WGT_W+1)'(1)) : quo_ff;
               rem_ff <= (PER_W+WGT_W)'(len_ff[2]) << WGT_W;
               quo_ff <= '0;
            end else if (per_ff != '0 && rem_sh >= per_al) begin
               rem_ff <= rem_sh - per_al;
               quo_ff <= quo_ff | ((WGT_W+1)'(1) << step_ff[4:0]);
            end
         end
         ST_CENTER: begin
            prod_ff <= (CRD_W+WGT_W+3)'(mul_p);
            if (step_ff == 6'd0) acc_ff <= '0;
            else acc_ff <= (CRD_W+WGT_W+4)'(prod_ff);
         end
         ST_CSUM: begin
            ctr_ff[side_ff] <= (CRD_W+2)'(crd(job_ff.shape, 2'd0, side_ff))
                             + (CRD_W+2)'((acc_ff + (CRD_W+WGT_W+4)'(prod_ff)) >>> WGT_W);
         end
         ST_INSET: begin
            if (step_ff == 6'd0) begin
               prod_ff <= (CRD_W+WGT_W+3)'(mul_p);
            end else begin
               if (ins_sum > (CRD_W+3)'(32'sh7FFFFFFF))
                  ins_ff[sub_ff][side_ff] <= 32'sh7FFFFFFF;
               else if (ins_sum < -(CRD_W+3)'(33'sh080000000))
                  ins_ff[sub_ff][side_ff] <= 32'sh80000000;
               else
                  ins_ff[sub_ff][side_ff] <= CRD_W'(ins_sum);
            end
         end
         default: ;
      endcase
   end

   // record formatting
   logic [IDX_W-1:0] j0, j1, j2, ia, ib, ic;
   always_comb begin
      j0 = job_ff.base;
      j1 = job_ff.base + IDX_W'(1);
      j2 = job_ff.base + IDX_W'(2);
      ia = job_ff.shape.first_index;
      ib = job_ff.shape.second_index;
      ic = job_ff.shape.third_index;
      rsp_valid = state_ff == ST_EMIT;
      rsp_data  = '0;
      rsp_data.index_overflow = job_ff.ovf;
      rsp_data.last = rec_ff == 4'd8;
      case (rec_ff)
         4'd0, 4'd1, 4'd2: begin
            rsp_data.record_kind = KIND_VERTEX;
            rsp_data.vertex_x = ins_ff[rec_ff[1:0]][0];
            rsp_data.vertex_y = ins_ff[rec_ff[1:0]][1];
            rsp_data.vertex_z = ins_ff[rec_ff[1:0]][2];
         end
         4'd3: begin rsp_data.record_kind = KIND_FACE;
            rsp_data.face_first = j0; rsp_data.face_second = ia; rsp_data.face_third = ib; end
         4'd4: begin rsp_data.record_kind = KIND_FACE;
            rsp_data.face_first = j0; rsp_data.face_second = ib; rsp_data.face_third = j1; end
         4'd5: begin rsp_data.record_kind = KIND_FACE;
            rsp_data.face_first = j1; rsp_data.face_second = ib; rsp_data.face_third = ic; end
         4'd6: begin rsp_data.record_kind = KIND_FACE;
            rsp_data.face_first = j1; rsp_data.face_second = ic; rsp_data.face_third = j2; end
         4'd7: begin rsp_data.record_kind = KIND_FACE;
            rsp_data.face_first = j2; rsp_data.face_second = ic; rsp_data.face_third = ia; end
         default: begin rsp_data.record_kind = KIND_FACE;
            rsp_data.face_first = j2; rsp_data.face_second = ia; rsp_data.face_third = j0; end
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      job_pop |-> state_ff == ST_IDLE && job_ready)
      else $error("job taken while busy");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rec_ff <= 4'd8)
      else $error("record counter past ninth record");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last && !rsp_stall |=> state_ff == ST_IDLE)
      else $error("engine did not return to idle after last record");

endmodule

// File: src/triangle_incenter_frame_split.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_incenter_frame_split: inset triangle frame generator
// Emits three inset vertices and six frame faces per triangle.
// ----------------------------------------------------------------------------
// Each triangle passes through three side lengths with 34-step square roots,
// two 17-step divisions, then incenter and inset on one multiplier before its
// first record. The shared geometry engine takes a new triangle only after
// emitting the last record of the previous one; a two-entry queue lets
// intake run ahead by two triangles.
// Reset: synchronous; vertex count zero, fraction one half, base zero.
module triangle_incenter_frame_split import tri_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_type            req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_type            rsp_data,
   input  logic               csr_write,
   input  logic [CSR_A_W-1:0] csr_index,
   input  logic [CSR_W-1:0]   csr_data
);

   logic [FRAC_W-1:0] fraction_ff;
   logic [IDX_W-1:0]  base_ff;
   logic    job_valid, q_full, q_ready, q_pop;
   job_type job_in, job_out;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fraction_ff <= FRAC_W'(32768);
         base_ff     <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_FRACTION: fraction_ff <= csr_data[FRAC_W-1:0];
            CSR_BASE:     base_ff     <= csr_data[IDX_W-1:0];
            default: ;
         endcase
      end
   end

   tri_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .vertex_base(base_ff), .job_valid, .job_full(q_full), .job_data(job_in)
   );

   tri_queue u_queue (
      .clock, .reset, .push(job_valid), .push_data(job_in), .full(q_full),
      .not_empty(q_ready), .pop(q_pop), .pop_data(job_out)
   );

   tri_back u_back (
      .clock, .reset, .job_ready(q_ready), .job_data(job_out), .job_pop(q_pop),
      .inset_fraction(fraction_ff), .rsp_valid, .rsp_stall, .rsp_data
   );

endmodule

// File: tb/sv/triangle_incenter_frame_split_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_incenter_frame_split_test: self-checking bench for the frame split
// Drives triangles through the request channel and predicts each triangle's
// nine records: three inset vertices and six frame faces. Every record is
// compared field by field. The configuration moves through several fraction
// and base settings, including the index overflow region. Both sides idle at
// random, and the receiver holds off long enough to fill the block.
// ----------------------------------------------------------------------------
module triangle_incenter_frame_split_test;
   import tri_pkg::*;

   localparam int WATCHDOG_LIMIT = 6000;
   localparam int DRAIN_CYCLES   = 250;
   localparam int HOLD_CYCLES    = 800;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   req_type            req_data;
   logic               rsp_valid;
   logic               rsp_stall;
   rsp_type            rsp_data;
   logic               csr_write;
   logic [CSR_A_W-1:0] csr_index;
   logic [CSR_W-1:0]   csr_data;

   req_type     pending_tris[$];
   rsp_type     expected_records[$];
   logic [15:0] fraction;
   logic [23:0] base_index;
   logic [23:0] vertex_count;
   int          errors;
   int          quiet_cycles;
   bit          calm;
   bit          hold_request;
   int          hold_left;

   triangle_incenter_frame_split dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // floor of the square root of a sum of three squares
   function automatic logic [33:0] edge_length(longint dx, longint dy, longint dz);
      logic [67:0] sum;
      logic [67:0] mx, my, mz, sq;
      logic [33:0] root, cand;
      mx = (dx < 0) ? 68'(-dx) : 68'(dx);
      my = (dy < 0) ? 68'(-dy) : 68'(dy);
      mz = (dz < 0) ? 68'(-dz) : 68'(dz);
      sum = mx * mx + my * my + mz * mz;
      root = '0;
      for (int k = 33; k >= 0; k--) begin
         cand = root | (34'd1 << k);
         sq = 68'(cand) * 68'(cand);
         if (sq <= sum) root = cand;
      end
      return root;
   endfunction

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // work out the nine records of one triangle and advance the vertex count
   task automatic predict_frame(input req_type t);
      longint  pt[3][3];
      longint  ctr[3];
      longint  sum;
      longint  ofs;
      logic [63:0] la, lb, lc, per, wb, wc, j, nv;
      logic    ovf;
      logic [23:0] ix[3];
      logic [63:0] fc[6][3];
      rsp_type r;
      pt[0][0] = t.ax; pt[0][1] = t.ay;       pt[0][2] = t.az;
      pt[1][0] = t.bx; pt[1][1] = t.by_coord; pt[1][2] = t.bz;
      pt[2][0] = t.cx; pt[2][1] = t.cy;       pt[2][2] = t.cz;
      la = 64'(edge_length(pt[1][0]-pt[2][0], pt[1][1]-pt[2][1], pt[1][2]-pt[2][2]));
      lb = 64'(edge_length(pt[2][0]-pt[0][0], pt[2][1]-pt[0][1], pt[2][2]-pt[0][2]));
      lc = 64'(edge_length(pt[0][0]-pt[1][0], pt[0][1]-pt[1][1], pt[0][2]-pt[1][2]));
      per = la + lb + lc;
      wb = 0;
      wc = 0;
      if (per != 0) begin
         wb = (lb << 16) / per;
         wc = (lc << 16) / per;
      end
      for (int a = 0; a < 3; a++) begin
         sum = longint'(wb) * (pt[1][a] - pt[0][a]) + longint'(wc) * (pt[2][a] - pt[0][a]);
         ctr[a] = pt[0][a] + (sum >>> 16);
      end
      j = 64'(base_index) + 64'(vertex_count);
      ovf = (j + 2 > 64'hffffff);
      nv = 64'(vertex_count) + 3;
      vertex_count = (nv > 64'hffffff) ? 24'hffffff : nv[23:0];
      ix[0] = t.first_index; ix[1] = t.second_index; ix[2] = t.third_index;
      fc[0] = '{j, ix[0], ix[1]};     fc[1] = '{j, ix[1], j + 1};
      fc[2] = '{j + 1, ix[1], ix[2]}; fc[3] = '{j + 1, ix[2], j + 2};
      fc[4] = '{j + 2, ix[2], ix[0]}; fc[5] = '{j + 2, ix[0], j};
      for (int n = 0; n < 9; n++) begin
         r = '0;
         if (n < 3) begin
            r.record_kind = KIND_VERTEX;
            ofs = longint'(fraction) * (ctr[0] - pt[n][0]);
            r.vertex_x = clamp32(pt[n][0] + (ofs >>> 16));
            ofs = longint'(fraction) * (ctr[1] - pt[n][1]);
            r.vertex_y = clamp32(pt[n][1] + (ofs >>> 16));
            ofs = longint'(fraction) * (ctr[2] - pt[n][2]);
            r.vertex_z = clamp32(pt[n][2] + (ofs >>> 16));
         end else begin
            r.record_kind = KIND_FACE;
            r.face_first  = fc[n-3][0][23:0];
            r.face_second = fc[n-3][1][23:0];
            r.face_third  = fc[n-3][2][23:0];
         end
         r.index_overflow = ovf;
         r.last = (n == 8);
         expected_records.push_back(r);
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH %s: got %h expected %h", what, got, want);
      errors++;
   endtask

   // request driver: predicts on acceptance, then offers the next triangle
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) predict_frame(req_data);
         if (req_valid && req_stall) begin
            // hold the stalled request
         end else if (pending_tris.size() > 0 && (calm || $urandom_range(99) >= 6)) begin
            req_data  <= pending_tris.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random stalls plus one long hold when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= (hold_left > 1);
      end else if (hold_request) begin
         hold_request <= 1'b0;
         hold_left    <= HOLD_CYCLES;
         rsp_stall    <= 1'b1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(99) < 6);
      end
   end

   // record monitor
   always @(posedge clock) begin
      rsp_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_records.size() == 0) begin
            $display("MISMATCH unexpected record %h", rsp_data);
            errors++;
         end else begin
            w = expected_records.pop_front();
            if (rsp_data.record_kind != w.record_kind)
               report_mismatch("record_kind", rsp_data.record_kind, w.record_kind);
            if (rsp_data.vertex_x != w.vertex_x)
               report_mismatch("vertex_x", rsp_data.vertex_x, w.vertex_x);
            if (rsp_data.vertex_y != w.vertex_y)
               report_mismatch("vertex_y", rsp_data.vertex_y, w.vertex_y);
            if (rsp_data.vertex_z != w.vertex_z)
               report_mismatch("vertex_z", rsp_data.vertex_z, w.vertex_z);
            if (rsp_data.face_first != w.face_first)
               report_mismatch("face_first", rsp_data.face_first, w.face_first);
            if (rsp_data.face_second != w.face_second)
               report_mismatch("face_second", rsp_data.face_second, w.face_second);
            if (rsp_data.face_third != w.face_third)
               report_mismatch("face_third", rsp_data.face_third, w.face_third);
            if (rsp_data.index_overflow != w.index_overflow)
               report_mismatch("index_overflow", rsp_data.index_overflow,
                               w.index_overflow);
            if (rsp_data.last != w.last)
               report_mismatch("last", rsp_data.last, w.last);
         end
      end
   end

   // watchdog on cycles with no handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("triangle_incenter_frame_split verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic signed [31:0] pick_coord(int style, logic signed [31:0] anchor);
      case (style)
         0: return $urandom;
         1: return anchor + $signed($urandom_range(131072)) - 32'sd65536;
         default: return $signed($urandom_range(65535) << $urandom_range(15));
      endcase
   endfunction

   function automatic req_type random_tri();
      req_type t;
      int style;
      style = $urandom_range(9);
      t.first_index  = 24'($urandom);
      t.second_index = 24'($urandom);
      t.third_index  = 24'($urandom);
      if (style < 3) begin
         t.ax = $urandom; t.ay = $urandom; t.az = $urandom;
         t.bx = $urandom; t.by_coord = $urandom; t.bz = $urandom;
         t.cx = $urandom; t.cy = $urandom; t.cz = $urandom;
      end else if (style == 9) begin
         // degenerate: all corners on one point
         t.ax = $urandom; t.ay = $urandom; t.az = $urandom;
         t.bx = t.ax; t.by_coord = t.ay; t.bz = t.az;
         t.cx = t.ax; t.cy = t.ay; t.cz = t.az;
      end else begin
         t.ax = pick_coord(2, 0); t.ay = pick_coord(2, 0); t.az = pick_coord(2, 0);
         t.bx = pick_coord(1, t.ax); t.by_coord = pick_coord(1, t.ay);
         t.bz = pick_coord(1, t.az);
         t.cx = pick_coord(1, t.ax); t.cy = pick_coord(1, t.ay);
         t.cz = pick_coord(1, t.az);
      end
      return t;
   endfunction

   function automatic req_type flat_tri(logic signed [31:0] a, logic signed [31:0] b,
                                        logic signed [31:0] c, logic [23:0] id);
      req_type t;
      t.first_index = id; t.second_index = ~id; t.third_index = id ^ 24'h5a5a5a;
      t.ax = a; t.ay = b; t.az = c;
      t.bx = b; t.by_coord = c; t.bz = a;
      t.cx = c; t.cy = a; t.cz = b;
      return t;
   endfunction

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_tris.size() > 0 || req_valid || expected_records.size() > 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_A_W-1:0] idx, input logic [CSR_W-1:0] val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      if (idx == CSR_FRACTION) fraction = val[15:0];
      else base_index = val;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   initial begin
      req_type t;
      errors = 0;
      calm = 1'b0;
      hold_request = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_write = 1'b0;
      csr_index = CSR_FRACTION;
      csr_data = '0;
      fraction = 16'd32768;
      base_index = '0;
      vertex_count = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, zero perimeter, collinear, index extremes
      pending_tris.push_back(flat_tri(32'sh7fffffff, 32'sh80000000, 32'sh0, 24'h0));
      pending_tris.push_back(flat_tri(32'sh80000000, 32'sh80000000, 32'sh7fffffff,
                                      24'hffffff));
      pending_tris.push_back(flat_tri(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                                      24'h123456));
      pending_tris.push_back(flat_tri(32'sh0, 32'sh0, 32'sh0, 24'h0));
      pending_tris.push_back(flat_tri(32'sh00010000, 32'sh00020000, 32'sh00030000,
                                      24'h800000));
      t = flat_tri(32'sh0, 32'sh0, 32'sh0, 24'h7);
      t.bx = 32'sh00010000; t.cx = 32'sh00020000;   // collinear along x
      pending_tris.push_back(t);
      t = flat_tri(32'sh0, 32'sh0, 32'sh0, 24'h9);
      t.bx = 32'sh7fffffff; t.cy = 32'sh80000000;   // right angle, huge legs
      pending_tris.push_back(t);
      t = flat_tri(32'sh0, 32'sh0, 32'sh0, 24'ha);
      t.bx = 32'sh00000001;                          // one short side, C on A
      pending_tris.push_back(t);
      for (int n = 0; n < 6; n++) pending_tris.push_back(random_tri());
      wait_idle();

      // fraction near one, moderate base, long hold to back up the block
      write_reg(CSR_FRACTION, 24'hffff);
      write_reg(CSR_BASE, 24'd1000);
      hold_request = 1'b1;
      for (int n = 0; n < 140; n++) pending_tris.push_back(random_tri());
      wait_idle();

      // smallest fraction, base at the top so indices wrap
      write_reg(CSR_FRACTION, 24'h1);
      write_reg(CSR_BASE, 24'hffffff);
      for (int n = 0; n < 50; n++) pending_tris.push_back(random_tri());
      wait_idle();

      // base just below the wrap point: first two triangles clean, then overflow
      write_reg(CSR_BASE, 24'hffffff - 24'(vertex_count) - 24'd5);
      for (int n = 0; n < 6; n++) pending_tris.push_back(random_tri());
      wait_idle();

      // random settings, a stretch without idling first
      write_reg(CSR_FRACTION, 24'($urandom_range(65535, 1)));
      write_reg(CSR_BASE, 24'($urandom_range(4096)));
      calm = 1'b1;
      for (int n = 0; n < 60; n++) pending_tris.push_back(random_tri());
      wait_idle();
      calm = 1'b0;
      for (int n = 0; n < 140; n++) pending_tris.push_back(random_tri());
      wait_idle();

      if (errors == 0) begin
         $display("triangle_incenter_frame_split verification clean");
      end else begin
         $display("triangle_incenter_frame_split verification failed");
      end
      $finish;
   end

endmodule
